FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define SSD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included
`define SSD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/ssdst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ssdst_pkg;

  // Geometry defaults
  localparam int NUM_DIES_DEF  = 64;
  localparam int ADDR_BITS_DEF = 40;

  // Port field widths
  localparam int BYTE_ADDR_W = 40;
  localparam int BYTE_CNT_W  = 32;
  localparam int TIME_W      = 48;
  localparam int COST_W      = 20;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 20;

  // Working widths: end address, per-die counts, products
  localparam int EXT_W   = BYTE_ADDR_W + 1;
  localparam int CNT_W   = 32;
  localparam int PROD_W  = COST_W + CNT_W;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOG2_PAGE_SIZE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOG2_PAGES_PER_BLOCK  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOG2_BLOCKS_PER_DIE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RANDOM_READ_COST      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEQUENTIAL_READ_COST  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RANDOM_WRITE_COST     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SEQUENTIAL_WRITE_COST = 3'd6;

  // Register reset values
  localparam logic [4:0] LOG2_PAGE_SIZE_RST       = 5'd12;
  localparam logic [3:0] LOG2_PAGES_PER_BLOCK_RST = 4'd6;
  localparam logic [4:0] LOG2_BLOCKS_PER_DIE_RST  = 5'd10;

endpackage

`default_nettype wire

FILE: rtl/ssd_request_service_time.sv
`timescale 1ns / 1ps
`default_nettype none
// Flow: SETUP, RANGE, then RD/EVAL/MULE/MULF/ACC per die the request spans, then DONE;
//   zero-length and out-of-range requests go from RANGE straight to DONE.
// One request at a time, taken only after DONE hands off the last result; the shared
//   20x32 multiplier and saturating adder visit each die in turn (offset read, evaluate,
//   two products, sum). Reset: synchronous, active low; config registers take their
//   defaults, then the offset memory is cleared one entry per cycle with in_tready low.

`include "assert_macros.svh"

module ssd_request_service_time
  import ssdst_pkg::*;
#(
  parameter int NUM_DIES  = NUM_DIES_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration write port
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  // request channel
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [71:0]           in_tdata,   // [39:0] byte_address, [71:40] byte_count
  input  wire logic                  in_tuser,   // [0] func (0 read, 1 write)
  // result channel
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [47:0]                out_tdata,  // [47:0] service_time
  output logic                       out_tuser   // [0] rejected
);

  localparam int DIE_W = (NUM_DIES > 1) ? $clog2(NUM_DIES) : 1;
  localparam logic [EXT_W-1:0] ONES  = '1;
  localparam logic [EXT_W-1:0] AMASK = (ADDR_BITS >= EXT_W) ? ONES
                                      : ~(ONES << ADDR_BITS);
  localparam logic [DIE_W-1:0] DIE_LAST = DIE_W'(NUM_DIES - 1);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_SETUP, S_RANGE, S_RD, S_EVAL, S_MULE, S_MULF, S_ACC, S_DONE
  } state_t;

  // Config registers
  logic [4:0]        log2_page_size_r;
  logic [3:0]        log2_pages_per_block_r;
  logic [4:0]        log2_blocks_per_die_r;
  logic [COST_W-1:0] random_read_cost_r;
  logic [COST_W-1:0] sequential_read_cost_r;
  logic [COST_W-1:0] random_write_cost_r;
  logic [COST_W-1:0] sequential_write_cost_r;

  // Control
  state_t           state_r, state_nxt;
  logic [DIE_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic             out_tvalid_r, out_tvalid_nxt;

  // Datapath
  logic                 wr_r, wr_nxt;
  logic [EXT_W-1:0]     a_r, a_nxt;
  logic [BYTE_CNT_W-1:0] len_r, len_nxt;
  logic [EXT_W-1:0]     end_r, end_nxt;
  logic [DIE_W-1:0]     i_r, i_nxt;
  logic [DIE_W-1:0]     first_r, first_nxt;
  logic [DIE_W-1:0]     last_r, last_nxt;
  logic [EXT_W-1:0]     c_r, c_nxt;
  logic [EXT_W-1:0]     d_r, d_nxt;
  logic [CNT_W-1:0]     e_r, e_nxt;
  logic [CNT_W-1:0]     span_r, span_nxt;
  logic [CNT_W-1:0]     f_r, f_nxt;
  logic [PROD_W-1:0]    prod_r, prod_nxt;
  logic [TIME_W-1:0]    total_r, total_nxt;
  logic                 rej_r, rej_nxt;
  logic [TIME_W-1:0]    out_time_r, out_time_nxt;
  logic                 out_rej_r, out_rej_nxt;

  // Offset memory
  logic [ADDR_BITS-1:0] offs_mem [NUM_DIES];
  logic [ADDR_BITS-1:0] mem_q_r;
  logic                 mem_we;
  logic [DIE_W-1:0]     mem_wa;
  logic [ADDR_BITS-1:0] mem_wd;

  // Geometry shifts
  logic [5:0]        lb;
  logic [6:0]        ld;
  logic [EXT_W-1:0]  blk_mask;
  logic [EXT_W-1:0]  die_mask;
  logic [COST_W-1:0] rcost;
  logic [COST_W-1:0] scost;

  // Shared unit operands and helpers
  logic [COST_W-1:0] mul_a;
  logic [CNT_W-1:0]  mul_b;
  logic [TIME_W:0]   sum_w;
  logic [TIME_W-1:0] sat_sum;
  logic [EXT_W-1:0]  i_ext;
  logic [EXT_W-1:0]  last_w;
  logic [EXT_W-1:0]  blocks_w;
  logic              hit;
  logic [CNT_W-1:0]  f_sh;
  logic              out_free;

  assign lb       = 6'(log2_page_size_r) + 6'(log2_pages_per_block_r);
  assign ld       = 7'(lb) + 7'(log2_blocks_per_die_r);
  assign blk_mask = ~(ONES << lb);
  assign die_mask = ~(ONES << ld);
  assign rcost    = wr_r ? random_write_cost_r : random_read_cost_r;
  assign scost    = wr_r ? sequential_write_cost_r : sequential_read_cost_r;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_time_r;
  assign out_tuser  = out_rej_r;
  assign out_free   = !out_tvalid_r || out_tready;

  // Saturating accumulate of the last product; a product past the time range saturates
  assign sum_w   = (TIME_W+1)'(total_r) + (TIME_W+1)'(prod_r[TIME_W-1:0]);
  assign sat_sum = ((|prod_r[PROD_W-1:TIME_W]) || sum_w[TIME_W]) ? TIME_MAX
                                                                 : sum_w[TIME_W-1:0];

  // Shared multiplier: random cost then sequential cost
  assign mul_a = (state_r == S_MULE) ? rcost : scost;
  assign mul_b = (state_r == S_MULE) ? e_r : f_r;

  assign i_ext    = EXT_W'(i_r);
  assign last_w   = end_r >> ld;
  assign blocks_w = (d_r >> lb) - (c_r >> lb) + EXT_W'(1);
  assign hit      = (mem_q_r == ADDR_BITS'(c_r & die_mask & AMASK)) &&
                    ((c_r & blk_mask) != '0);
  assign f_sh     = (span_r - e_r) >> log2_page_size_r;

  // Sequencer and datapath next values
  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    wr_nxt         = wr_r;
    a_nxt          = a_r;
    len_nxt        = len_r;
    end_nxt        = end_r;
    i_nxt          = i_r;
    first_nxt      = first_r;
    last_nxt       = last_r;
    c_nxt          = c_r;
    d_nxt          = d_r;
    e_nxt          = e_r;
    span_nxt       = span_r;
    f_nxt          = f_r;
    prod_nxt       = prod_r;
    total_nxt      = total_r;
    rej_nxt        = rej_r;
    out_time_nxt   = out_time_r;
    out_rej_nxt    = out_rej_r;
    mem_we         = 1'b0;
    mem_wa         = i_r;
    mem_wd         = '0;
    case (state_r)
      S_CLR: begin
        // sweep zeros through the offset memory
        mem_we = 1'b1;
        mem_wa = clr_cnt_r;
        if (clr_cnt_r == DIE_LAST) begin
          state_nxt = S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + DIE_W'(1);
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          wr_nxt    = in_tuser;
          a_nxt     = EXT_W'(in_tdata[BYTE_ADDR_W-1:0]) & AMASK;
          len_nxt   = in_tdata[BYTE_ADDR_W +: BYTE_CNT_W];
          total_nxt = '0;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        end_nxt = a_r + EXT_W'(len_r) - EXT_W'(1);
        state_nxt = S_RANGE;
      end
      S_RANGE: begin
        // reject empty requests and those ending past the last die
        first_nxt = DIE_W'(a_r >> ld);
        last_nxt  = DIE_W'(last_w);
        i_nxt     = DIE_W'(a_r >> ld);
        if ((len_r == '0) || (last_w >= EXT_W'(NUM_DIES))) begin
          rej_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else begin
          rej_nxt   = 1'b0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        // bound this die's part of the request; offset read in flight
        c_nxt = (i_r == first_r) ? a_r : (i_ext << ld);
        d_nxt = (i_r == last_r) ? end_r : (((i_ext + EXT_W'(1)) << ld) - EXT_W'(1));
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        // count random accesses and store the new die offset
        e_nxt    = CNT_W'(blocks_w) - CNT_W'(hit);
        span_nxt = CNT_W'(d_r - c_r + EXT_W'(1));
        mem_we   = 1'b1;
        mem_wd   = ADDR_BITS'((d_r + EXT_W'(1)) & die_mask & AMASK);
        state_nxt = S_MULE;
      end
      S_MULE: begin
        prod_nxt  = mul_a * mul_b;
        f_nxt     = (f_sh == '0) ? CNT_W'(1) : f_sh;
        state_nxt = S_MULF;
      end
      S_MULF: begin
        prod_nxt  = mul_a * mul_b;
        total_nxt = sat_sum;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        total_nxt = sat_sum;
        if (i_r == last_r) begin
          state_nxt = S_DONE;
        end else begin
          i_nxt     = i_r + DIE_W'(1);
          state_nxt = S_RD;
        end
      end
      S_DONE: begin
        // hand off once the output register is free
        if (out_free) begin
          out_time_nxt   = rej_r ? '0 : total_r;
          out_rej_nxt    = rej_r;
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state, config, datapath and registered outputs
  always_ff @(posedge clk) begin
    wr_r       <= wr_nxt;
    a_r        <= a_nxt;
    len_r      <= len_nxt;
    end_r      <= end_nxt;
    i_r        <= i_nxt;
    first_r    <= first_nxt;
    last_r     <= last_nxt;
    c_r        <= c_nxt;
    d_r        <= d_nxt;
    e_r        <= e_nxt;
    span_r     <= span_nxt;
    f_r        <= f_nxt;
    prod_r     <= prod_nxt;
    total_r    <= total_nxt;
    rej_r      <= rej_nxt;
    out_time_r <= out_time_nxt;
    out_rej_r  <= out_rej_nxt;
    if (!rst_n) begin
      state_r                 <= S_CLR;
      clr_cnt_r               <= '0;
      out_tvalid_r            <= 1'b0;
      log2_page_size_r        <= LOG2_PAGE_SIZE_RST;
      log2_pages_per_block_r  <= LOG2_PAGES_PER_BLOCK_RST;
      log2_blocks_per_die_r   <= LOG2_BLOCKS_PER_DIE_RST;
      random_read_cost_r      <= '0;
      sequential_read_cost_r  <= '0;
      random_write_cost_r     <= '0;
      sequential_write_cost_r <= '0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          REG_LOG2_PAGE_SIZE:        log2_page_size_r        <= cfg_wdata[4:0];
          REG_LOG2_PAGES_PER_BLOCK:  log2_pages_per_block_r  <= cfg_wdata[3:0];
          REG_LOG2_BLOCKS_PER_DIE:   log2_blocks_per_die_r   <= cfg_wdata[4:0];
          REG_RANDOM_READ_COST:      random_read_cost_r      <= cfg_wdata;
          REG_SEQUENTIAL_READ_COST:  sequential_read_cost_r  <= cfg_wdata;
          REG_RANDOM_WRITE_COST:     random_write_cost_r     <= cfg_wdata;
          REG_SEQUENTIAL_WRITE_COST: sequential_write_cost_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // Offset memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      offs_mem[mem_wa] <= mem_wd;
    end
    mem_q_r <= offs_mem[i_r];
  end

  // Checks
  `SSD_ASSERT_ALWAYS(a_reset_blocks_input, !rst_n |=> !in_tready, "input ready right after reset")
  `SSD_ASSERT(a_busy_after_accept, (in_tvalid && in_tready) |=> !in_tready, "ready while busy")
  `SSD_ASSERT(a_die_in_range, (state_r == S_RD) |-> (i_r <= last_r), "die index past last die")
  `SSD_ASSERT(a_reject_zero_time, (out_tvalid && out_tuser) |-> (out_tdata == '0), "rejected with time")

endmodule

`default_nettype wire
